FILE: design/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types, widths and codes for the lidar point filter and transform.
// ----------------------------------------------------------------------------
package lpf_pkg;

   // Scan geometry limits and field widths.
   localparam int INF_LIMIT_M = 1000;
   localparam int INDEX_BITS  = 16;
   localparam int COORD_W     = 32;
   localparam int COEFF_W     = 48;
   localparam int INTENS_W    = 8;
   localparam int STAMP_W     = 64;
   localparam int POSE_DEPTH  = 12;
   localparam int POSE_IDX_W  = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int FILT_W      = 3;

   // Pose store layout: rotation row-major, then translation x, y, z.
   localparam int AXES        = 3;
   localparam int NUM_TERMS   = AXES * AXES;
   localparam int POSE_TRANS  = NUM_TERMS;

   // Multiplier split: a 48-bit coefficient is cut into a 24-bit unsigned low
   // half and a 24-bit signed high half.
   localparam int SPLIT_W     = 24;
   localparam int LO_PROD_W   = COORD_W + SPLIT_W + 1;
   localparam int HI_PROD_W   = COORD_W + COEFF_W - SPLIT_W;
   localparam int FULL_PROD_W = COORD_W + COEFF_W;
   localparam int ACC_W       = FULL_PROD_W + 3;
   localparam int FRAC_SHIFT  = 30;

   // Filter enable bits.
   localparam int FILT_HUGE   = 0;
   localparam int FILT_BOX    = 1;
   localparam int FILT_HIGH_Z = 2;

   // Magnitude limit for the huge-point test, Q15.16.
   localparam logic signed [COORD_W-1:0] HUGE_POS = COORD_W'(INF_LIMIT_M * 65536);
   localparam logic signed [COORD_W-1:0] HUGE_NEG = COORD_W'(-(INF_LIMIT_M * 65536));

   // Identity rotation entry, 1.0 in Q17.30.
   localparam logic signed [COEFF_W-1:0] ONE_Q30 = COEFF_W'(64'sd1 <<< FRAC_SHIFT);

   // Input beat kinds.
   localparam logic MODE_POINT = 1'b0;
   localparam logic MODE_POSE  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_EN  = 3'd0,
      CSR_BOX_FWD_X  = 3'd1,
      CSR_BOX_BWD_X  = 3'd2,
      CSR_BOX_FWD_Y  = 3'd3,
      CSR_BOX_BWD_Y  = 3'd4,
      CSR_Z_THRESH   = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [FILT_W-1:0]         filter_en;
      logic signed [COORD_W-1:0] box_fwd_x;
      logic signed [COORD_W-1:0] box_bwd_x;
      logic signed [COORD_W-1:0] box_fwd_y;
      logic signed [COORD_W-1:0] box_bwd_y;
      logic signed [COORD_W-1:0] z_thresh;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [INTENS_W-1:0]       intensity;
      logic [STAMP_W-1:0]        stamp_ns;
      logic [INDEX_BITS-1:0]     point_index;
   } point_type;

   typedef logic signed [COEFF_W-1:0] coeff_type;
   typedef coeff_type [POSE_DEPTH-1:0] pose_type;

endpackage

FILE: design/lpf_req_if.sv
// ----------------------------------------------------------------------------
// lpf_req_if
// Input channel: one point or one pose coefficient write per beat.
// ----------------------------------------------------------------------------
interface lpf_req_if import lpf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic                      point_invalid;
   logic [INTENS_W-1:0]       intensity;
   logic [STAMP_W-1:0]        stamp_ns;
   logic [INDEX_BITS-1:0]     point_index;
   logic [POSE_IDX_W-1:0]     coeff_index;
   logic signed [COEFF_W-1:0] coeff_value;

   modport source (
      output valid, mode, pos_x, pos_y, pos_z, point_invalid, intensity,
             stamp_ns, point_index, coeff_index, coeff_value,
      input  ready
   );

   modport sink (
      input  valid, mode, pos_x, pos_y, pos_z, point_invalid, intensity,
             stamp_ns, point_index, coeff_index, coeff_value,
      output ready
   );
endinterface

FILE: design/lpf_rsp_if.sv
// ----------------------------------------------------------------------------
// lpf_rsp_if
// Result channel: one kept point with its world coordinates per beat.
// ----------------------------------------------------------------------------
interface lpf_rsp_if import lpf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] local_x;
   logic signed [COORD_W-1:0] local_y;
   logic signed [COORD_W-1:0] local_z;
   logic signed [COEFF_W-1:0] world_x;
   logic signed [COEFF_W-1:0] world_y;
   logic signed [COEFF_W-1:0] world_z;
   logic [INTENS_W-1:0]       out_intensity;
   logic [STAMP_W-1:0]        out_stamp_ns;
   logic [INDEX_BITS-1:0]     out_index;

   modport source (
      output valid, local_x, local_y, local_z, world_x, world_y, world_z,
             out_intensity, out_stamp_ns, out_index,
      input  ready
   );

   modport sink (
      input  valid, local_x, local_y, local_z, world_x, world_y, world_z,
             out_intensity, out_stamp_ns, out_index,
      output ready
   );
endinterface

FILE: design/lpf_csr.sv
// ----------------------------------------------------------------------------
// lpf_csr
// Filter configuration registers behind a plain write port.
// ----------------------------------------------------------------------------
module lpf_csr import lpf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            CSR_FILTER_EN: cfg_in.filter_en = csr_wdata[FILT_W-1:0];
            CSR_BOX_FWD_X: cfg_in.box_fwd_x = signed'(csr_wdata[COORD_W-1:0]);
            CSR_BOX_BWD_X: cfg_in.box_bwd_x = signed'(csr_wdata[COORD_W-1:0]);
            CSR_BOX_FWD_Y: cfg_in.box_fwd_y = signed'(csr_wdata[COORD_W-1:0]);
            CSR_BOX_BWD_Y: cfg_in.box_bwd_y = signed'(csr_wdata[COORD_W-1:0]);
            CSR_Z_THRESH:  cfg_in.z_thresh  = signed'(csr_wdata[COORD_W-1:0]);
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/lpf_pose_store.sv
// ----------------------------------------------------------------------------
// lpf_pose_store
// Twelve pose coefficients; resets to the identity rotation, zero translation.
// ----------------------------------------------------------------------------
module lpf_pose_store import lpf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [POSE_IDX_W-1:0] wr_index,
   input  coeff_type             wr_value,
   output pose_type              pose
);

   pose_type pose_ff;
   pose_type pose_in;

   // Identity rotation with zero translation.
   function automatic pose_type identity_pose();
      pose_type p;
      p = '0;
      for (int r = 0; r < AXES; r++) begin
         p[r * AXES + r] = ONE_Q30;
      end
      return p;
   endfunction

   // Indexes beyond the translation entries are ignored.
   always_comb begin
      pose_in = pose_ff;
      for (int i = 0; i < POSE_DEPTH; i++) begin
         if (wr_en && (wr_index == POSE_IDX_W'(i))) begin
            pose_in[i] = wr_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_ff <= identity_pose();
      end else begin
         pose_ff <= pose_in;
      end
   end

   assign pose = pose_ff;

endmodule

FILE: design/lpf_filter.sv
// ----------------------------------------------------------------------------
// lpf_filter
// Keep/drop decision for one point from its coordinates and the filter set-up.
// ----------------------------------------------------------------------------
module lpf_filter import lpf_pkg::*; (
   input  point_type point,
   input  logic      point_invalid,
   input  cfg_type   cfg,
   output logic      keep
);

   logic huge;
   logic drop_bad;
   logic drop_box;
   logic drop_high_z;

   always_comb begin
      huge = (point.pos_x > HUGE_POS) || (point.pos_x < HUGE_NEG) ||
             (point.pos_y > HUGE_POS) || (point.pos_y < HUGE_NEG) ||
             (point.pos_z > HUGE_POS) || (point.pos_z < HUGE_NEG);

      drop_bad = cfg.filter_en[FILT_HUGE] && (point_invalid || huge);

      // The vehicle box is open on all four sides.
      drop_box = cfg.filter_en[FILT_BOX] &&
                 (point.pos_x < cfg.box_fwd_x) && (point.pos_x > cfg.box_bwd_x) &&
                 (point.pos_y < cfg.box_fwd_y) && (point.pos_y > cfg.box_bwd_y);

      drop_high_z = cfg.filter_en[FILT_HIGH_Z] && (point.pos_z > cfg.z_thresh);

      keep = !(drop_bad || drop_box || drop_high_z);
   end

endmodule

FILE: design/lpf_transform.sv
// ----------------------------------------------------------------------------
// lpf_transform
// Four-stage multiply-add pipeline computing R * p + t, rounded and saturated.
// ----------------------------------------------------------------------------
module lpf_transform import lpf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  point_type  in_point,
   input  pose_type   in_pose,
   output logic       out_valid,
   input  logic       out_ready,
   output point_type  out_point,
   output coeff_type  out_world_x,
   output coeff_type  out_world_y,
   output coeff_type  out_world_z
);

   // Stage enables: a stage loads when it is empty or its successor loads.
   logic en_b, en_c, en_d, en_e;

   logic signed [COORD_W-1:0] coord [AXES];

   // Stage B: split partial products and translation.
   logic signed [LO_PROD_W-1:0] prod_lo_in [NUM_TERMS];
   logic signed [HI_PROD_W-1:0] prod_hi_in [NUM_TERMS];
   logic signed [LO_PROD_W-1:0] prod_lo_ff [NUM_TERMS];
   logic signed [HI_PROD_W-1:0] prod_hi_ff [NUM_TERMS];
   coeff_type                   trans_b_in [AXES];
   coeff_type                   trans_b_ff [AXES];
   point_type                   point_b_ff;
   logic                        valid_b_ff;

   // Stage C: full 80-bit products.
   logic signed [FULL_PROD_W-1:0] full_in [NUM_TERMS];
   logic signed [FULL_PROD_W-1:0] full_ff [NUM_TERMS];
   coeff_type                     trans_c_ff [AXES];
   point_type                     point_c_ff;
   logic                          valid_c_ff;

   // Stage D: row sums with translation and rounding constant.
   logic signed [ACC_W-1:0] acc_in [AXES];
   logic signed [ACC_W-1:0] acc_ff [AXES];
   point_type               point_d_ff;
   logic                    valid_d_ff;

   // Stage E: output register.
   coeff_type world_in [AXES];
   coeff_type world_ff [AXES];
   point_type point_e_ff;
   logic      valid_e_ff;

   function automatic coeff_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W-FRAC_SHIFT-COEFF_W:0] upper;
      coeff_type                          res;
      upper = acc[ACC_W-1:FRAC_SHIFT+COEFF_W-1];
      if ((&upper) || !(|upper)) begin
         res = acc[FRAC_SHIFT+COEFF_W-1:FRAC_SHIFT];
      end else if (acc[ACC_W-1]) begin
         res = {1'b1, {(COEFF_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(COEFF_W-1){1'b1}}};
      end
      return res;
   endfunction

   assign en_e     = !valid_e_ff || out_ready;
   assign en_d     = !valid_d_ff || en_e;
   assign en_c     = !valid_c_ff || en_d;
   assign en_b     = !valid_b_ff || en_c;
   assign in_ready = en_b;

   assign coord[0] = in_point.pos_x;
   assign coord[1] = in_point.pos_y;
   assign coord[2] = in_point.pos_z;

   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         for (int c = 0; c < AXES; c++) begin
            prod_lo_in[r * AXES + c] =
               $signed({1'b0, in_pose[r * AXES + c][SPLIT_W-1:0]}) * coord[c];
            prod_hi_in[r * AXES + c] =
               $signed(in_pose[r * AXES + c][COEFF_W-1:SPLIT_W]) * coord[c];
         end
         trans_b_in[r] = in_pose[POSE_TRANS + r];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_TERMS; k++) begin
         full_in[k] = (FULL_PROD_W'(prod_hi_ff[k]) <<< SPLIT_W) +
                      FULL_PROD_W'(prod_lo_ff[k]);
      end
   end

   // Translation moves to Q.46 with the half-LSB rounding bit set below it.
   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         acc_in[r] = ACC_W'(full_ff[r * AXES]) +
                     ACC_W'(full_ff[r * AXES + 1]) +
                     ACC_W'(full_ff[r * AXES + 2]) +
                     ACC_W'($signed({trans_c_ff[r], 1'b1, {(FRAC_SHIFT-1){1'b0}}}));
      end
   end

   always_comb begin
      for (int r = 0; r < AXES; r++) begin
         world_in[r] = round_sat(acc_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
      end else begin
         if (en_b) begin
            valid_b_ff <= in_valid;
         end
         if (en_c) begin
            valid_c_ff <= valid_b_ff;
         end
         if (en_d) begin
            valid_d_ff <= valid_c_ff;
         end
         if (en_e) begin
            valid_e_ff <= valid_d_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         trans_b_ff <= trans_b_in;
         point_b_ff <= in_point;
      end
      if (en_c) begin
         full_ff    <= full_in;
         trans_c_ff <= trans_b_ff;
         point_c_ff <= point_b_ff;
      end
      if (en_d) begin
         acc_ff     <= acc_in;
         point_d_ff <= point_c_ff;
      end
      if (en_e) begin
         world_ff   <= world_in;
         point_e_ff <= point_d_ff;
      end
   end

   assign out_valid   = valid_e_ff;
   assign out_point   = point_e_ff;
   assign out_world_x = world_ff[0];
   assign out_world_y = world_ff[1];
   assign out_world_z = world_ff[2];

endmodule

FILE: design/lidar_point_filter_transform.sv
// ----------------------------------------------------------------------------
// lidar_point_filter_transform
// Crop-box filter and rigid transform for a stream of lidar points.
// ----------------------------------------------------------------------------
// Each beat on req_bus carries either a point (mode 0) or a write of one pose
// coefficient (mode 1). Points that survive the enabled filters (invalid or
// huge, inside the vehicle box, above the z threshold) leave on rsp_bus with
// their sensor-frame coordinates and their world coordinates R * p + t,
// rounded half up to Q31.16 and saturated to 48 bits. Dropped points and pose
// writes produce no beat on rsp_bus.
// The filter registers are written through the csr_ port, one register per
// cycle with csr_wr_en high; they are meant to be changed only while no point
// is in flight. A pose write takes effect for every point accepted after it.
// Throughput is one beat per cycle while rsp_bus does not stall. A kept point
// passes through the input register, partial products, full products, row
// sums, then the output register before it appears on rsp_bus.
// Reset clears the pipeline and the filter registers and loads the identity
// rotation with zero translation; the block accepts beats in the next cycle.
// When rsp_bus stalls, every stage holds its beat and bubbles are squeezed
// out, so req_bus only backs up once all five stages are full.
// ----------------------------------------------------------------------------
module lidar_point_filter_transform import lpf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lpf_req_if.sink               req_bus,
   lpf_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg;
   pose_type pose;

   // Stage A: the input register.
   logic                  valid_a_ff;
   logic                  mode_a_ff;
   logic                  invalid_a_ff;
   point_type             point_a_ff;
   point_type             point_a_in;
   logic [POSE_IDX_W-1:0] coeff_index_a_ff;
   coeff_type             coeff_value_a_ff;

   logic keep;
   logic point_kept;
   logic xf_ready;
   logic en_a;
   logic pose_wr_en;

   point_type out_point;

   lpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // A pose write sitting in stage A always leaves at the next edge, so it
   // updates the store exactly once, after every earlier point has already
   // taken its products and before any later point reaches stage A.
   assign pose_wr_en = valid_a_ff && (mode_a_ff == MODE_POSE);

   lpf_pose_store u_pose_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pose_wr_en),
      .wr_index (coeff_index_a_ff),
      .wr_value (coeff_value_a_ff),
      .pose     (pose)
   );

   lpf_filter u_filter (
      .point         (point_a_ff),
      .point_invalid (invalid_a_ff),
      .cfg           (cfg),
      .keep          (keep)
   );

   assign point_kept = valid_a_ff && (mode_a_ff == MODE_POINT) && keep;

   // Stage A empties whenever its beat is not a kept point, or the transform
   // pipeline takes that point.
   assign en_a          = !valid_a_ff || !point_kept || xf_ready;
   assign req_bus.ready = en_a;

   lpf_transform u_transform (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (point_kept),
      .in_ready    (xf_ready),
      .in_point    (point_a_ff),
      .in_pose     (pose),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_point   (out_point),
      .out_world_x (rsp_bus.world_x),
      .out_world_y (rsp_bus.world_y),
      .out_world_z (rsp_bus.world_z)
   );

   always_comb begin
      point_a_in.pos_x       = req_bus.pos_x;
      point_a_in.pos_y       = req_bus.pos_y;
      point_a_in.pos_z       = req_bus.pos_z;
      point_a_in.intensity   = req_bus.intensity;
      point_a_in.stamp_ns    = req_bus.stamp_ns;
      point_a_in.point_index = req_bus.point_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en_a) begin
         valid_a_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && req_bus.valid) begin
         mode_a_ff        <= req_bus.mode;
         invalid_a_ff     <= req_bus.point_invalid;
         point_a_ff       <= point_a_in;
         coeff_index_a_ff <= req_bus.coeff_index;
         coeff_value_a_ff <= req_bus.coeff_value;
      end
   end

   assign rsp_bus.local_x       = out_point.pos_x;
   assign rsp_bus.local_y       = out_point.pos_y;
   assign rsp_bus.local_z       = out_point.pos_z;
   assign rsp_bus.out_intensity = out_point.intensity;
   assign rsp_bus.out_stamp_ns  = out_point.stamp_ns;
   assign rsp_bus.out_index     = out_point.point_index;

endmodule

FILE: tb/lidar_point_filter_transform_test.sv
// ----------------------------------------------------------------------------
// lidar_point_filter_transform_test
// Self-checking bench for the lidar crop-box filter and rigid transform.
// ----------------------------------------------------------------------------
// A short directed table covers the reset pose, the field extremes, the
// saturation and rounding corners and every filter, and is followed by
// several phases of random beats under different filter settings and
// handshake pressure. Every result beat is checked field by field against an
// in-bench model of the filter and fixed-point transform or typed-in world values.
// ----------------------------------------------------------------------------
module lidar_point_filter_transform_test;
   import lpf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 9;
   // Allow a good margin beyond the depth of the block's pipeline, so that
   // dropped points and pose writes have surely left the pipeline.
   localparam int PIPE_FLUSH      = 16;
   localparam int RAND_PHASES     = 7;
   localparam int ITEMS_PER_PHASE = 115;
   localparam int REPORT_LIMIT    = 10;

   localparam int     COORD_MAX = 2147483647;
   localparam int     COORD_MIN = -2147483647 - 1;
   localparam int     HUGE_LIM  = INF_LIMIT_M * 65536;
   localparam longint POSE_MAX  = (64'sd1 <<< (COEFF_W - 1)) - 1;
   localparam longint POSE_MIN  = -(64'sd1 <<< (COEFF_W - 1));
   localparam logic signed [95:0] WORLD_MAX  = (96'sd1 <<< (COEFF_W - 1)) - 1;
   localparam logic signed [95:0] WORLD_MIN  = -(96'sd1 <<< (COEFF_W - 1));
   localparam logic signed [95:0] ROUND_HALF = 96'sd1 <<< (FRAC_SHIFT - 1);

   typedef enum {STEP_BEAT, STEP_CSR} step_kind_type;
   // How the expected outcome of a directed row is obtained: from the model,
   // as a point that must vanish, or with world coordinates typed in.
   typedef enum {CHK_PREDICT, CHK_DROP, CHK_WORLD} check_kind_type;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_type;

   typedef struct {
      logic                 mode;
      point_type            pt;
      logic                 invalid;
      logic [POSE_IDX_W-1:0] coeff_index;
      coeff_type            coeff_value;
   } beat_type;

   typedef struct {
      step_kind_type  kind;
      csr_reg_type    csr_reg;
      logic [CSR_DATA_W-1:0] csr_val;
      beat_type       beat;
      check_kind_type chk;
      longint         wx, wy, wz;
   } test_row_type;

   typedef struct {
      logic signed [COORD_W-1:0] lx, ly, lz;
      logic signed [COEFF_W-1:0] wx, wy, wz;
      logic [INTENS_W-1:0]       intensity;
      logic [STAMP_W-1:0]        stamp;
      logic [INDEX_BITS-1:0]     index;
   } kept_point_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lpf_req_if req_bus ();
   lpf_rsp_if rsp_bus ();

   lidar_point_filter_transform uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Bench copy of the block's state: the pose store and the filter registers.
   coeff_type                 pose_model [POSE_DEPTH];
   logic [FILT_W-1:0]         filt_en;
   logic signed [COORD_W-1:0] box_fx, box_bx, box_fy, box_by, z_thr;

   // Points that the model says will come out, oldest first.
   kept_point_type kept_points [$];
   int             fault_count = 0;
   idle_kind_type  idle_mode   = IDLE_NONE;

   // ------------------------------------------------------------------------
   // Model of the block
   // ------------------------------------------------------------------------

   function automatic longint magnitude(logic signed [COORD_W-1:0] v);
      longint w;
      w = v;
      return (w < 0) ? -w : w;
   endfunction

   // A point survives unless one of the enabled filters claims it. With the
   // huge-point filter off, an invalid point is treated like any other.
   function automatic bit point_kept(beat_type b);
      logic signed [COORD_W-1:0] x, y, z;
      x = b.pt.pos_x;
      y = b.pt.pos_y;
      z = b.pt.pos_z;
      if (filt_en[FILT_HUGE]) begin
         if (b.invalid) return 1'b0;
         if (magnitude(x) > HUGE_LIM || magnitude(y) > HUGE_LIM ||
             magnitude(z) > HUGE_LIM) return 1'b0;
      end
      if (filt_en[FILT_BOX] && x < box_fx && x > box_bx && y < box_fy && y > box_by)
         return 1'b0;
      if (filt_en[FILT_HIGH_Z] && z > z_thr) return 1'b0;
      return 1'b1;
   endfunction

   // One row of R * p + t. The products are summed exactly in 96 bits, the
   // translation is lifted to the same Q.46 scale, half an output LSB is added
   // so that ties go towards plus infinity, and the result is saturated.
   function automatic logic signed [COEFF_W-1:0] world_axis(int row,
         logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
         logic signed [COORD_W-1:0] z);
      logic signed [95:0]        acc, term, coord;
      logic signed [COORD_W-1:0] p [AXES];
      int                        k;
      p[0] = x;
      p[1] = y;
      p[2] = z;
      acc = ROUND_HALF;
      for (k = 0; k < AXES; k++) begin
         term  = pose_model[row * AXES + k];
         coord = p[k];
         acc   = acc + term * coord;
      end
      term = pose_model[POSE_TRANS + row];
      acc  = acc + (term <<< FRAC_SHIFT);
      acc  = acc >>> FRAC_SHIFT;
      if (acc > WORLD_MAX) acc = WORLD_MAX;
      else if (acc < WORLD_MIN) acc = WORLD_MIN;
      return acc[COEFF_W-1:0];
   endfunction

   function automatic kept_point_type transform_point(beat_type b);
      kept_point_type k;
      k.lx        = b.pt.pos_x;
      k.ly        = b.pt.pos_y;
      k.lz        = b.pt.pos_z;
      k.wx        = world_axis(0, b.pt.pos_x, b.pt.pos_y, b.pt.pos_z);
      k.wy        = world_axis(1, b.pt.pos_x, b.pt.pos_y, b.pt.pos_z);
      k.wz        = world_axis(2, b.pt.pos_x, b.pt.pos_y, b.pt.pos_z);
      k.intensity = b.pt.intensity;
      k.stamp     = b.pt.stamp_ns;
      k.index     = b.pt.point_index;
      return k;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------------

   // Coordinates cluster where the decisions are made: near the huge limit,
   // near a box bound or the z threshold, at the extremes of the field, and
   // in a plausible range around the vehicle, with plain noise besides.
   function automatic logic signed [COORD_W-1:0] pick_coord(
         logic signed [COORD_W-1:0] lo, logic signed [COORD_W-1:0] hi);
      int d;
      d = int'($urandom_range(0, 8)) - 4;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return int'($urandom_range(0, 400 << 16)) - (200 << 16);
         2: return ($urandom_range(0, 1) ? HUGE_LIM : -HUGE_LIM) + d;
         3: return ($urandom_range(0, 1) ? lo : hi) + d;
         4: begin
            case ($urandom_range(0, 3))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return int'($urandom_range(0, 40 << 16)) - (20 << 16);
      endcase
   endfunction

   // A random beat: mostly points, some pose writes. Index values past the
   // end of the pose store are included, and the fields that a beat of the
   // other kind ignores are filled with noise.
   function automatic test_row_type random_row();
      test_row_type r;
      r.kind    = STEP_BEAT;
      r.csr_reg = CSR_FILTER_EN;
      r.csr_val = '0;
      r.chk     = CHK_PREDICT;
      r.wx      = 0;
      r.wy      = 0;
      r.wz      = 0;
      r.beat.mode           = ($urandom_range(0, 99) < 15) ? MODE_POSE : MODE_POINT;
      r.beat.pt.pos_x       = pick_coord(box_bx, box_fx);
      r.beat.pt.pos_y       = pick_coord(box_by, box_fy);
      r.beat.pt.pos_z       = pick_coord(z_thr, z_thr);
      r.beat.invalid        = ($urandom_range(0, 7) == 0);
      r.beat.pt.intensity   = INTENS_W'($urandom);
      r.beat.pt.stamp_ns    = {$urandom, $urandom};
      r.beat.pt.point_index = INDEX_BITS'($urandom);
      r.beat.coeff_index    = POSE_IDX_W'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
         0: r.beat.coeff_value =
               COEFF_W'(longint'($urandom_range(0, 32'h8000_0000)) - (64'sd1 <<< 30));
         1: r.beat.coeff_value = COEFF_W'({$urandom, $urandom});
         2: r.beat.coeff_value =
               COEFF_W'(longint'($urandom_range(0, 2000 << 16)) - (1000 << 16));
         default: begin
            case ($urandom_range(0, 3))
               0: r.beat.coeff_value = COEFF_W'(POSE_MAX);
               1: r.beat.coeff_value = COEFF_W'(POSE_MIN);
               2: r.beat.coeff_value = '0;
               default: r.beat.coeff_value = ONE_Q30;
            endcase
         end
      endcase
      return r;
   endfunction

   function automatic test_row_type point_row(int x, int y, int z, bit invalid,
         check_kind_type chk, longint wx = 0, longint wy = 0, longint wz = 0);
      test_row_type r;
      r = random_row();
      r.beat.mode     = MODE_POINT;
      r.beat.pt.pos_x = x;
      r.beat.pt.pos_y = y;
      r.beat.pt.pos_z = z;
      r.beat.invalid  = invalid;
      r.chk           = chk;
      r.wx            = wx;
      r.wy            = wy;
      r.wz            = wz;
      return r;
   endfunction

   function automatic test_row_type pose_row(int idx, longint value);
      test_row_type r;
      r = random_row();
      r.beat.mode        = MODE_POSE;
      r.beat.coeff_index = POSE_IDX_W'(idx);
      r.beat.coeff_value = COEFF_W'(value);
      return r;
   endfunction

   function automatic test_row_type csr_row(csr_reg_type which,
         logic [CSR_DATA_W-1:0] value);
      test_row_type r;
      r         = random_row();
      r.kind    = STEP_CSR;
      r.csr_reg = which;
      r.csr_val = value;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // Presents one beat after a random idle gap, waits for it to be taken and
   // then records what the block should make of it. Valid is left high on
   // return, so the next call either follows straight on or lowers it.
   task automatic drive_row(input test_row_type r);
      int pct;
      pct = (idle_mode == IDLE_SENDER) ? 86 : (idle_mode == IDLE_BOTH) ? 34 : 0;
      while ($urandom_range(0, 99) < pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= r.beat.mode;
      req_bus.pos_x         <= r.beat.pt.pos_x;
      req_bus.pos_y         <= r.beat.pt.pos_y;
      req_bus.pos_z         <= r.beat.pt.pos_z;
      req_bus.point_invalid <= r.beat.invalid;
      req_bus.intensity     <= r.beat.pt.intensity;
      req_bus.stamp_ns      <= r.beat.pt.stamp_ns;
      req_bus.point_index   <= r.beat.pt.point_index;
      req_bus.coeff_index   <= r.beat.coeff_index;
      req_bus.coeff_value   <= r.beat.coeff_value;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);

      // The beat has been taken at this edge.
      case (r.chk)
         CHK_PREDICT: begin
            if (r.beat.mode == MODE_POSE) begin
               if (r.beat.coeff_index < POSE_DEPTH)
                  pose_model[r.beat.coeff_index] = r.beat.coeff_value;
            end else if (point_kept(r.beat)) begin
               kept_points = {kept_points, transform_point(r.beat)};
            end
         end
         CHK_WORLD: begin
            kept_points = {kept_points, transform_point(r.beat)};
            kept_points[$].wx = COEFF_W'(r.wx);
            kept_points[$].wy = COEFF_W'(r.wy);
            kept_points[$].wz = COEFF_W'(r.wz);
         end
         default: ;
      endcase
   endtask

   // Registers may only change with nothing in flight, so the bench lets the
   // pipeline run empty first.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (kept_points.size() != 0) @(posedge clock);
      repeat (PIPE_FLUSH) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type which, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      case (which)
         CSR_FILTER_EN: filt_en = value[FILT_W-1:0];
         CSR_BOX_FWD_X: box_fx  = value;
         CSR_BOX_BWD_X: box_bx  = value;
         CSR_BOX_FWD_Y: box_fy  = value;
         CSR_BOX_BWD_Y: box_by  = value;
         CSR_Z_THRESH:  z_thr   = value;
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Checking of result beats
   // ------------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [63:0] want,
         input logic [63:0] got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   task automatic take_result();
      kept_point_type k;
      if (kept_points.size() == 0) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT)
            $display("%0t: result beat with none expected, index %h world %h %h %h",
                     $realtime, rsp_bus.out_index, rsp_bus.world_x, rsp_bus.world_y,
                     rsp_bus.world_z);
      end else begin
         k = kept_points.pop_front();
         compare_field("local_x", 64'(k.lx), 64'(rsp_bus.local_x));
         compare_field("local_y", 64'(k.ly), 64'(rsp_bus.local_y));
         compare_field("local_z", 64'(k.lz), 64'(rsp_bus.local_z));
         compare_field("world_x", 64'(k.wx), 64'(rsp_bus.world_x));
         compare_field("world_y", 64'(k.wy), 64'(rsp_bus.world_y));
         compare_field("world_z", 64'(k.wz), 64'(rsp_bus.world_z));
         compare_field("out_intensity", 64'(k.intensity), 64'(rsp_bus.out_intensity));
         compare_field("out_stamp_ns", k.stamp, rsp_bus.out_stamp_ns);
         compare_field("out_index", 64'(k.index), 64'(rsp_bus.out_index));
      end
   endtask

   // The receiver samples at each rising edge and then chooses, at random for
   // the stalling phases, whether it will take a beat at the next edge.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            take_result();
         case (idle_mode)
            IDLE_RECEIVER: rsp_bus.ready <= ($urandom_range(0, 99) >= 86);
            IDLE_BOTH:     rsp_bus.ready <= ($urandom_range(0, 99) >= 34);
            default:       rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin
      test_row_type          rows [$];
      test_row_type          r;
      int                    ph, i;
      logic [CSR_DATA_W-1:0] en, fx, bx, fy, by, thr;

      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_FILTER_EN;
      csr_wdata             <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.mode          <= MODE_POINT;
      req_bus.pos_x         <= '0;
      req_bus.pos_y         <= '0;
      req_bus.pos_z         <= '0;
      req_bus.point_invalid <= 1'b0;
      req_bus.intensity     <= '0;
      req_bus.stamp_ns      <= '0;
      req_bus.point_index   <= '0;
      req_bus.coeff_index   <= '0;
      req_bus.coeff_value   <= '0;

      // The model starts in the reset state: identity rotation, no offset,
      // every filter off and every bound at zero.
      for (i = 0; i < POSE_DEPTH; i++) pose_model[i] = '0;
      pose_model[0] = ONE_Q30;
      pose_model[4] = ONE_Q30;
      pose_model[8] = ONE_Q30;
      filt_en = '0;
      box_fx  = '0;
      box_bx  = '0;
      box_fy  = '0;
      box_by  = '0;
      z_thr   = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table. With the reset pose a point comes out unchanged, so
      // its world coordinates are simply the sensor ones on the Q.16 scale.
      r = point_row(1 << 16, -(2 << 16), 3 << 16, 1'b0, CHK_WORLD,
                    1 << 16, -(2 << 16), 3 << 16);
      r.beat.pt.intensity   = '0;
      r.beat.pt.stamp_ns    = '0;
      r.beat.pt.point_index = '0;
      rows = {rows, r};
      // Extreme coordinates and pass-through fields; the invalid flag has no
      // effect while the huge-point filter is off.
      r = point_row(COORD_MAX, COORD_MIN, 0, 1'b1, CHK_WORLD, COORD_MAX, COORD_MIN, 0);
      r.beat.pt.intensity   = '1;
      r.beat.pt.stamp_ns    = '1;
      r.beat.pt.point_index = '1;
      rows = {rows, r};
      // A pose write beyond the store is ignored.
      rows = {rows, pose_row(15, 48'h1234_5678_9abc)};
      rows = {rows, point_row(0, 0, 0, 1'b0, CHK_WORLD, 0, 0, 0)};
      // The largest and smallest translations pass straight through.
      rows = {rows, pose_row(POSE_TRANS, POSE_MAX)};
      rows = {rows, point_row(0, 0, 0, 1'b0, CHK_WORLD, POSE_MAX, 0, 0)};
      rows = {rows, pose_row(POSE_TRANS, POSE_MIN)};
      rows = {rows, point_row(0, 0, 0, 1'b0, CHK_WORLD, POSE_MIN, 0, 0)};
      rows = {rows, point_row(-1, 0, 0, 1'b0, CHK_PREDICT)};
      rows = {rows, pose_row(POSE_TRANS, 0)};
      // A rotation entry of one half makes the rounding ties visible.
      rows = {rows, pose_row(0, 64'sd1 <<< 29)};
      rows = {rows, point_row(1, 0, 0, 1'b0, CHK_PREDICT)};
      rows = {rows, point_row(-1, 0, 0, 1'b0, CHK_PREDICT)};
      rows = {rows, pose_row(0, ONE_Q30)};
      // Invalid and huge points, with a point exactly on the limit kept.
      rows = {rows, csr_row(CSR_FILTER_EN, 1 << FILT_HUGE)};
      rows = {rows, point_row(0, 0, 0, 1'b1, CHK_DROP)};
      rows = {rows, point_row(HUGE_LIM + 1, 0, 0, 1'b0, CHK_DROP)};
      rows = {rows, point_row(HUGE_LIM, 0, 0, 1'b0, CHK_PREDICT)};
      rows = {rows, point_row(0, 0, -HUGE_LIM - 1, 1'b0, CHK_DROP)};
      // Vehicle box: inside is dropped, a point on a bound is kept.
      rows = {rows, csr_row(CSR_BOX_FWD_X, 10 << 16)};
      rows = {rows, csr_row(CSR_BOX_BWD_X, -(10 << 16))};
      rows = {rows, csr_row(CSR_BOX_FWD_Y, 5 << 16)};
      rows = {rows, csr_row(CSR_BOX_BWD_Y, -(5 << 16))};
      rows = {rows, csr_row(CSR_FILTER_EN, 1 << FILT_BOX)};
      rows = {rows, point_row(0, 0, 0, 1'b0, CHK_DROP)};
      rows = {rows, point_row(10 << 16, 0, 0, 1'b0, CHK_PREDICT)};
      // High z: the threshold itself is kept, one LSB above is not.
      rows = {rows, csr_row(CSR_Z_THRESH, 2 << 16)};
      rows = {rows, csr_row(CSR_FILTER_EN, 1 << FILT_HIGH_Z)};
      rows = {rows, point_row(0, 0, 2 << 16, 1'b0, CHK_PREDICT)};
      rows = {rows, point_row(0, 0, (2 << 16) + 1, 1'b0, CHK_DROP)};

      foreach (rows[k]) begin
         if (rows[k].kind == STEP_CSR) begin
            settle();
            write_csr(rows[k].csr_reg, rows[k].csr_val);
         end else begin
            drive_row(rows[k]);
         end
      end

      // Random phases. The first three use extreme settings: everything off,
      // an empty box with the highest threshold, and a box covering the whole
      // field. The rest pick moderate bounds around the vehicle.
      for (ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: begin
               en = '0; fx = '0; bx = '0; fy = '0; by = '0; thr = '0;
            end
            1: begin
               en  = '1;
               fx  = COORD_MIN; bx = COORD_MAX;
               fy  = COORD_MIN; by = COORD_MAX;
               thr = COORD_MAX;
            end
            2: begin
               en  = 1 << FILT_BOX;
               fx  = COORD_MAX; bx = COORD_MIN;
               fy  = COORD_MAX; by = COORD_MIN;
               thr = COORD_MIN;
            end
            default: begin
               en  = $urandom_range(0, 7);
               fx  = $urandom_range(0, 20 << 16);
               bx  = -int'($urandom_range(0, 20 << 16));
               fy  = $urandom_range(0, 10 << 16);
               by  = -int'($urandom_range(0, 10 << 16));
               thr = int'($urandom_range(0, 10 << 16)) - (5 << 16);
            end
         endcase
         settle();
         idle_mode = idle_kind_type'(ph % 4);
         write_csr(CSR_FILTER_EN, en);
         write_csr(CSR_BOX_FWD_X, fx);
         write_csr(CSR_BOX_BWD_X, bx);
         write_csr(CSR_BOX_FWD_Y, fy);
         write_csr(CSR_BOX_BWD_Y, by);
         write_csr(CSR_Z_THRESH, thr);
         repeat (ITEMS_PER_PHASE) drive_row(random_row());
      end

      // Let every outstanding point arrive, then watch a little longer for
      // any stray beat.
      settle();
      if (fault_count == 0)
         $display("lidar_point_filter_transform_test passed");
      else
         $display("lidar_point_filter_transform_test failed");
      $finish;
   end

   // Watchdog: the slowest legitimate run needs well under a tenth of this.
   initial begin
      #5ms;
      $display("lidar_point_filter_transform_test failed");
      $finish;
   end

endmodule
